@@ hw/rtl/ubds_pkg.sv @@
// Shared types and constants for the UART baud divisor search block.
`timescale 1ns / 1ps

package ubds_pkg;

    // Field widths
    localparam int CLK_W    = 28;
    localparam int BAUD_W   = 24;
    localparam int OSR_W    = 6;
    localparam int STATUS_W = 2;
    localparam int DEN_W    = BAUD_W + OSR_W;

    // Parameter defaults
    localparam int OSR_MAX_DEF      = 32;
    localparam int DIVISOR_BITS_DEF = 13;

    // Ratio limits
    localparam logic [OSR_W-1:0] OSR_MIN       = OSR_W'(4);
    localparam logic [OSR_W-1:0] BOTH_EDGE_TOP = OSR_W'(7);

    // Reset value of the source clock register
    localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(48000000);

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLK_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLK_LOW  = 2'd2;

    // Per-candidate info that travels alongside the divider chains
    typedef struct packed {
        logic                first;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [BAUD_W-1:0]   baud;
        logic [OSR_W-1:0]    osr;
    } ubds_side_t;

endpackage

@@ hw/rtl/ubds_div_cell.sv @@
// One restoring-division cell: settles a single quotient bit per cycle while adv is high.
`timescale 1ns / 1ps

module ubds_div_cell
    import ubds_pkg::*;
#(
    parameter int BIT = 0,
    parameter int SW  = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic [CLK_W-1:0] clk_hz,
    input  logic             valid_in,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [DEN_W-1:0] den_in,
    input  logic [CLK_W-1:0] quo_in,
    input  logic [SW-1:0]    side_in,
    output logic             valid_out,
    output logic [DEN_W-1:0] rem_out,
    output logic [DEN_W-1:0] den_out,
    output logic [CLK_W-1:0] quo_out,
    output logic [SW-1:0]    side_out
);

    logic             valid_reg;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CLK_W-1:0] quo_reg, quo_next;
    logic [SW-1:0]    side_reg;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
        trial    = {rem_in, clk_hz[BIT]};
        diff     = trial - {1'b0, den_in};
        ge       = trial >= {1'b0, den_in};
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_next = quo_in;
        quo_next[BIT] = ge;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign den_out   = den_reg;
    assign quo_out   = quo_reg;
    assign side_out  = side_reg;

endmodule

@@ hw/rtl/ubds_div_pipe.sv @@
// Chain of division cells: source clock divided by a per-candidate denominator.
`timescale 1ns / 1ps

module ubds_div_pipe
    import ubds_pkg::*;
#(
    parameter int SW = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic [CLK_W-1:0] clk_hz,
    input  logic             valid_in,
    input  logic [DEN_W-1:0] den_in,
    input  logic [SW-1:0]    side_in,
    output logic             valid_out,
    output logic [CLK_W-1:0] quo_out,
    output logic [SW-1:0]    side_out
);

    logic             v_chain [CLK_W+1];
    logic [DEN_W-1:0] r_chain [CLK_W+1];
    logic [DEN_W-1:0] d_chain [CLK_W+1];
    logic [CLK_W-1:0] q_chain [CLK_W+1];
    logic [SW-1:0]    s_chain [CLK_W+1];

    // Chain head: empty remainder and quotient
    assign v_chain[0] = valid_in;
    assign r_chain[0] = '0;
    assign d_chain[0] = den_in;
    assign q_chain[0] = '0;
    assign s_chain[0] = side_in;

    // Cell k settles quotient bit CLK_W-1-k
    for (genvar k = 0; k < CLK_W; k++) begin : g_cell
        ubds_div_cell #(
            .BIT (CLK_W - 1 - k),
            .SW  (SW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .clk_hz    (clk_hz),
            .valid_in  (v_chain[k]),
            .rem_in    (r_chain[k]),
            .den_in    (d_chain[k]),
            .quo_in    (q_chain[k]),
            .side_in   (s_chain[k]),
            .valid_out (v_chain[k+1]),
            .rem_out   (r_chain[k+1]),
            .den_out   (d_chain[k+1]),
            .quo_out   (q_chain[k+1]),
            .side_out  (s_chain[k+1])
        );
    end

    assign valid_out = v_chain[CLK_W];
    assign quo_out   = q_chain[CLK_W];
    assign side_out  = s_chain[CLK_W];

endmodule

@@ hw/rtl/uart_baud_divisor_search.sv @@
// Top level of the UART baud divisor search block.
`timescale 1ns / 1ps

// Each accepted baud rate is expanded into one candidate per oversampling
// ratio (4 to OSR_MAX), issued one per cycle while the output is not stalled
// into two chains of division cells (one cell per quotient bit): the first
// finds the divisor clock / (baud * ratio), the second the achieved rate
// clock / (ratio * div). A new transaction is accepted in the same cycle as the
// last candidate of the previous one issues, so the issue stage sets the
// throughput. The result appears once the last candidate has passed both
// chains and the error stage; a stalled result holds the whole pipeline. The
// source clock register is written through the cfg channel, which is always
// ready, and must only change while no transaction is in flight.

module uart_baud_divisor_search
    import ubds_pkg::*;
#(
    parameter int OSR_MAX      = OSR_MAX_DEF,
    parameter int DIVISOR_BITS = DIVISOR_BITS_DEF,
    parameter int OUT_W        = ((STATUS_W + OSR_W + DIVISOR_BITS + 1 + CLK_W + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CLK_W-1:0]  cfg_data,
    // Input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BAUD_W-1:0] s_tdata,   // [23:0] baud_rate
    // Result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    // status, oversample_ratio, baud_divisor, both_edge, baud_error
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int SIDE_W = $bits(ubds_side_t);
    localparam int SW_B   = SIDE_W + 1 + DIVISOR_BITS;
    localparam int PROD_W = OSR_W + DIVISOR_BITS;
    localparam logic [CLK_W-1:0] DIV_LIMIT = CLK_W'((1 << DIVISOR_BITS) - 1);
    localparam logic [OSR_W-1:0] OSR_TOP   = OSR_W'(OSR_MAX);

    logic adv;

    // Source clock register
    logic [CLK_W-1:0] clk_hz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg <= CLK_RESET;
        end else if (cfg_valid) begin
            clk_hz_reg <= cfg_data;
        end
    end

    // Global advance: the output register is free or being emptied
    assign adv = !m_tvalid || m_tready;

    // Issue stage: holds one transaction, sweeps the ratios
    logic                busy_reg;
    logic [BAUD_W-1:0]   baud_reg;
    logic [OSR_W-1:0]    osr_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [BAUD_W-1:0]   in_baud;
    logic [STATUS_W-1:0] in_status;
    logic                issue, issue_last, accept;

    assign issue      = busy_reg && adv;
    assign issue_last = issue && (osr_reg == OSR_TOP);
    assign s_tready   = !busy_reg || issue_last;
    assign accept     = s_tvalid && s_tready;

    always_comb begin
        in_baud = (s_tdata == '0) ? BAUD_W'(1) : s_tdata;
        if (clk_hz_reg == '0) begin
            in_status = ST_CLK_ZERO;
        end else if (clk_hz_reg < CLK_W'({in_baud, 2'b00})) begin
            in_status = ST_CLK_LOW;
        end else begin
            in_status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (accept) begin
            busy_reg <= 1'b1;
        end else if (issue_last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            baud_reg   <= in_baud;
            status_reg <= in_status;
            osr_reg    <= OSR_MIN;
        end else if (issue) begin
            osr_reg <= osr_reg + OSR_W'(1);
        end
    end

    // Denominator stage: baud * ratio
    logic             s0_valid_reg;
    logic [DEN_W-1:0] s0_den_reg;
    ubds_side_t       s0_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (adv) begin
            s0_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_den_reg         <= DEN_W'(baud_reg) * DEN_W'(osr_reg);
            s0_side_reg.first  <= (osr_reg == OSR_MIN);
            s0_side_reg.last   <= (osr_reg == OSR_TOP);
            s0_side_reg.status <= status_reg;
            s0_side_reg.baud   <= baud_reg;
            s0_side_reg.osr    <= osr_reg;
        end
    end

    // First chain: candidate divisor
    logic             a_valid;
    logic [CLK_W-1:0] a_quo;
    logic [SIDE_W-1:0] a_side_bits;
    ubds_side_t       a_side;

    ubds_div_pipe #(.SW(SIDE_W)) u_div_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .clk_hz    (clk_hz_reg),
        .valid_in  (s0_valid_reg),
        .den_in    (s0_den_reg),
        .side_in   (s0_side_reg),
        .valid_out (a_valid),
        .quo_out   (a_quo),
        .side_out  (a_side_bits)
    );

    assign a_side = ubds_side_t'(a_side_bits);

    // Saturate, mark zero divisors, form ratio * divisor
    logic [DIVISOR_BITS-1:0] a_div;
    logic                    s1_valid_reg;
    logic [DEN_W-1:0]        s1_den_reg;
    logic [SW_B-1:0]         s1_side_reg;
    logic [PROD_W-1:0]       a_prod;

    assign a_div  = (a_quo > DIV_LIMIT) ? DIV_LIMIT[DIVISOR_BITS-1:0]
                                        : a_quo[DIVISOR_BITS-1:0];
    assign a_prod = PROD_W'(a_side.osr) * PROD_W'(a_div);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_den_reg  <= DEN_W'(a_prod);
            s1_side_reg <= {a_side, (a_quo == '0), a_div};
        end
    end

    // Second chain: achieved rate
    logic             b_valid;
    logic [CLK_W-1:0] b_quo;
    logic [SW_B-1:0]  b_side_bits;
    ubds_side_t       b_side;
    logic             b_skip;
    logic [DIVISOR_BITS-1:0] b_div;

    ubds_div_pipe #(.SW(SW_B)) u_div_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .clk_hz    (clk_hz_reg),
        .valid_in  (s1_valid_reg),
        .den_in    (s1_den_reg),
        .side_in   (s1_side_reg),
        .valid_out (b_valid),
        .quo_out   (b_quo),
        .side_out  (b_side_bits)
    );

    assign {b_side, b_skip, b_div} = b_side_bits;

    // Error stage
    logic                    e_valid_reg;
    logic [CLK_W-1:0]        e_err_reg;
    ubds_side_t              e_side_reg;
    logic                    e_skip_reg;
    logic [DIVISOR_BITS-1:0] e_div_reg;
    logic [CLK_W-1:0]        b_baud;

    assign b_baud = CLK_W'(b_side.baud);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            e_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_err_reg  <= (b_quo > b_baud) ? (b_quo - b_baud) : (b_baud - b_quo);
            e_side_reg <= b_side;
            e_skip_reg <= b_skip;
            e_div_reg  <= b_div;
        end
    end

    // Best-candidate tracking; ties go to the later (larger) ratio
    logic                    best_none_reg, best_none_next;
    logic [OSR_W-1:0]        best_osr_reg, best_osr_next;
    logic [DIVISOR_BITS-1:0] best_div_reg, best_div_next;
    logic [CLK_W-1:0]        best_err_reg, best_err_next;
    logic                    take, base_none;

    always_comb begin
        base_none      = e_side_reg.first || best_none_reg;
        take           = !e_skip_reg && (base_none || (e_err_reg <= best_err_reg));
        best_none_next = base_none && !take;
        best_osr_next  = take ? e_side_reg.osr : (base_none ? '0 : best_osr_reg);
        best_div_next  = take ? e_div_reg : (base_none ? '0 : best_div_reg);
        best_err_next  = take ? e_err_reg : (base_none ? '0 : best_err_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv && e_valid_reg) begin
            best_none_reg <= best_none_next;
            best_osr_reg  <= best_osr_next;
            best_div_reg  <= best_div_next;
            best_err_reg  <= best_err_next;
        end
    end

    // Output register
    logic                    m_valid_reg;
    logic [STATUS_W-1:0]     m_status_reg;
    logic [OSR_W-1:0]        m_osr_reg;
    logic [DIVISOR_BITS-1:0] m_div_reg;
    logic                    m_both_reg;
    logic [CLK_W-1:0]        m_err_reg;
    logic                    res_ok;

    assign res_ok = (e_side_reg.status == ST_OK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= e_valid_reg && e_side_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && e_valid_reg && e_side_reg.last) begin
            m_status_reg <= e_side_reg.status;
            m_osr_reg    <= res_ok ? best_osr_next : '0;
            m_div_reg    <= res_ok ? best_div_next : '0;
            m_err_reg    <= res_ok ? best_err_next : '0;
            m_both_reg   <= res_ok && (best_osr_next >= OSR_MIN)
                                   && (best_osr_next <= BOTH_EDGE_TOP);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_err_reg, m_both_reg, m_div_reg, m_osr_reg, m_status_reg});

endmodule
